// ===== src/segment_manifest_parser_defines.svh =====
// ---------------------------------------------------------------------------
// segment_manifest_parser_defines.svh
// Assertion macros used by the manifest parser queue.
// ---------------------------------------------------------------------------
`ifndef SEGMENT_MANIFEST_PARSER_DEFINES_SVH
`define SEGMENT_MANIFEST_PARSER_DEFINES_SVH
`ifndef SYNTH
// property holds at every rising clock edge outside reset
`define SMP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");
// condition never true outside reset
`define SMP_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition seen");
`else
`define SMP_ASSERT(lbl, prop)
`define SMP_ASSERT_NEVER(lbl, cond)
`endif
`endif

// ===== src/smp_pkg.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smp_pkg
// Types, codes and helpers of the segment manifest parser.
// ---------------------------------------------------------------------------
package smp_pkg;

  localparam int unsigned CountWidthDefault = 24;
  localparam int unsigned QueueDepth = 2;

  // field tags
  localparam logic [3:0] TagVersion    = 4'd0;
  localparam logic [3:0] TagCounter    = 4'd1;
  localparam logic [3:0] TagSegCount   = 4'd2;
  localparam logic [3:0] TagNameByte   = 4'd3;
  localparam logic [3:0] TagDocs       = 4'd4;
  localparam logic [3:0] TagDelGen     = 4'd5;
  localparam logic [3:0] TagOffset     = 4'd6;
  localparam logic [3:0] TagStoreByte  = 4'd7;
  localparam logic [3:0] TagStoreCmpd  = 4'd8;
  localparam logic [3:0] TagSingleNorm = 4'd9;
  localparam logic [3:0] TagCompound   = 4'd10;
  localparam logic [3:0] TagError      = 4'd11;
  localparam logic [3:0] TagDone       = 4'd12;

  // error codes
  localparam logic [2:0] ErrNone      = 3'd0;
  localparam logic [2:0] ErrTruncated = 3'd1;
  localparam logic [2:0] ErrFormat    = 3'd2;
  localparam logic [2:0] ErrSegCount  = 3'd3;
  localparam logic [2:0] ErrDocCount  = 3'd4;
  localparam logic [2:0] ErrVint      = 3'd5;
  localparam logic [2:0] ErrSentinel  = 3'd6;

  // register indexes
  localparam logic [1:0] RegExpFormat = 2'd0;
  localparam logic [1:0] RegNoNormGen = 2'd1;
  localparam logic [1:0] RegMaxDocs   = 2'd2;
  localparam logic [1:0] RegBufBytes  = 2'd3;

  localparam logic [31:0] ExpFormatReset = 32'h0000_0000;
  localparam logic [31:0] NoNormGenReset = 32'hFFFF_FFFF;
  localparam logic [30:0] MaxDocsReset   = 31'(32'h1000_0000);
  localparam logic [23:0] BufBytesReset  = 24'd0;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [3:0]  field_tag;
    logic [63:0] field_value;
    logic [23:0] segment_number;
    logic        string_end;
    logic        empty_string;
    logic [2:0]  error_code;
    logic        manifest_done;
    logic        last_of_run;
  } out_t;

  typedef struct packed {
    logic [31:0] expected_format;
    logic [31:0] no_norm_gen_value;
    logic [30:0] max_docs;
    logic [23:0] buffer_bytes;
  } cfg_t;

  // one byte's worth of results, expanded by the back end
  typedef struct packed {
    logic        has_main;   // field, string or error result present
    logic [3:0]  tag;
    logic [63:0] value;      // code point when ulen != 0
    logic [2:0]  ulen;       // UTF-8 length, 0 for scalar results
    logic        str_end;
    logic        empty;
    logic [2:0]  err;
    logic [31:0] seg;
    logic        add_done;
    logic        add_trunc;
    logic [31:0] post_seg;   // segment index after the byte
  } desc_t;

  function automatic logic [7:0] utf8_byte(input logic [24:0] code,
                                           input logic [2:0] len,
                                           input logic [2:0] idx);
    logic [2:0]  j;
    logic [24:0] sh;
    logic [7:0]  r;
    j = len - idx - 3'd1;
    case (j)
      3'd0: sh = code;
      3'd1: sh = code >> 6;
      default: sh = code >> 12;
    endcase
    if (idx == 3'd0) begin
      case (len)
        3'd1: r = code[7:0];
        3'd2: r = 8'hC0 | code[13:6];
        3'd3: r = 8'hE0 | code[19:12];
        default: r = 8'hF0 | {1'b0, code[24:18]};
      endcase
    end else begin
      r = 8'h80 | {2'b00, sh[5:0]};
    end
    return r;
  endfunction

endpackage

// ===== src/smp_front.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smp_front
// Byte parser: advances the manifest state and posts at most one run descriptor per byte.
// ---------------------------------------------------------------------------
module smp_front #(
  parameter int unsigned COUNT_WIDTH = smp_pkg::CountWidthDefault
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             accept_i,
  input  smp_pkg::in_t     in_data_i,
  input  smp_pkg::cfg_t    cfg_i,
  output logic             push_o,
  output smp_pkg::desc_t   desc_o
);

  typedef enum logic [4:0] {
    PH_FORMAT         = 5'd0,
    PH_VERSION        = 5'd1,
    PH_COUNTER        = 5'd2,
    PH_SEGCOUNT       = 5'd3,
    PH_NAME_LEN       = 5'd4,
    PH_NAME_CHARS     = 5'd5,
    PH_DOCS           = 5'd6,
    PH_DELGEN         = 5'd7,
    PH_OFFSET         = 5'd8,
    PH_STORE_LEN      = 5'd9,
    PH_STORE_CHARS    = 5'd10,
    PH_STORE_COMPOUND = 5'd11,
    PH_NORM           = 5'd12,
    PH_NORMGEN        = 5'd13,
    PH_COMPOUND       = 5'd14
  } phase_e;

  localparam logic [31:0] CntMax = 32'((64'd1 << COUNT_WIDTH) - 64'd1);

  phase_e                  phase_q, phase_d;
  logic [2:0]              fbc_q, fbc_d;
  logic [63:0]             acc_q, acc_d;
  logic [5:0]              vsh_q, vsh_d;
  logic [30:0]             chars_q, chars_d;
  logic [1:0]              cbl_q, cbl_d;
  logic [24:0]             code_q, code_d;
  logic [COUNT_WIDTH-1:0]  segs_q, segs_d;
  logic [COUNT_WIDTH-1:0]  idx_q, idx_d;
  logic                    halted_q, halted_d;
  smp_pkg::desc_t          d;

  logic [7:0]              b;
  logic [63:0]             acc_n, vsh_bits;
  logic [31:0]             acc_l, v32;
  logic                    fld_last, is_name;
  logic [24:0]             code_c;
  logic [1:0]              cbl_c;
  logic [30:0]             chars_dec;
  logic [COUNT_WIDTH-1:0]  segs_dec;

  always_comb begin
    phase_d  = phase_q;
    fbc_d    = fbc_q;
    acc_d    = acc_q;
    vsh_d    = vsh_q;
    chars_d  = chars_q;
    cbl_d    = cbl_q;
    code_d   = code_q;
    segs_d   = segs_q;
    idx_d    = idx_q;
    halted_d = halted_q;
    d        = '0;
    d.seg    = 32'(idx_q);

    b        = in_data_i.data_byte;
    acc_n    = {acc_q[55:0], b};
    v32      = acc_n[31:0];
    fld_last = (phase_q == PH_VERSION || phase_q == PH_DELGEN) ? (fbc_q == 3'd7)
                                                               : (fbc_q == 3'd3);
    vsh_bits = 64'(b[6:0]) << vsh_q;
    acc_l    = acc_q[31:0] | vsh_bits[31:0];
    is_name  = (phase_q == PH_NAME_LEN) || (phase_q == PH_NAME_CHARS);
    chars_dec = chars_q - 31'd1;
    segs_dec  = segs_q - COUNT_WIDTH'(1);

    // modified-UTF byte assembly
    if (cbl_q == 2'd0) begin
      if (!b[7]) begin
        code_c = 25'(b);
        cbl_c  = 2'd0;
      end else if (b[7:5] == 3'b110) begin
        code_c = 25'(b[4:0]);
        cbl_c  = 2'd1;
      end else if (b[7:4] == 4'b1110) begin
        code_c = 25'(b[3:0]);
        cbl_c  = 2'd2;
      end else begin
        code_c = 25'(b[6:0]);
        cbl_c  = 2'd3;
      end
    end else begin
      code_c = {code_q[18:0], b[5:0]};
      cbl_c  = cbl_q - 2'd1;
    end

    if (accept_i) begin
      if (!halted_q) begin
        case (phase_q)
          PH_FORMAT, PH_VERSION, PH_COUNTER, PH_SEGCOUNT,
          PH_DOCS, PH_DELGEN, PH_OFFSET, PH_NORMGEN: begin
            acc_d = acc_n;
            fbc_d = fld_last ? 3'd0 : fbc_q + 3'd1;
            if (fld_last) begin
              d.has_main = 1'b1;
              case (phase_q)
                PH_FORMAT: begin
                  if (v32 != cfg_i.expected_format) begin
                    d.tag = smp_pkg::TagError; d.err = smp_pkg::ErrFormat;
                    halted_d = 1'b1;
                  end else begin
                    d.has_main = 1'b0;
                    phase_d = PH_VERSION;
                  end
                end
                PH_VERSION: begin
                  d.tag = smp_pkg::TagVersion; d.value = acc_n;
                  phase_d = PH_COUNTER;
                end
                PH_COUNTER: begin
                  d.tag = smp_pkg::TagCounter; d.value = {{32{v32[31]}}, v32};
                  phase_d = PH_SEGCOUNT;
                end
                PH_SEGCOUNT: begin
                  if (v32[31] || v32 > 32'(cfg_i.buffer_bytes) || v32 > CntMax) begin
                    d.tag = smp_pkg::TagError; d.err = smp_pkg::ErrSegCount;
                    halted_d = 1'b1;
                  end else begin
                    d.tag = smp_pkg::TagSegCount; d.value = 64'(v32);
                    segs_d = v32[COUNT_WIDTH-1:0];
                    idx_d  = '0;
                    if (v32 == 32'd0) begin
                      d.add_done = 1'b1;
                      halted_d   = 1'b1;
                    end else begin
                      phase_d = PH_NAME_LEN; vsh_d = '0; acc_d = '0;
                    end
                  end
                end
                PH_DOCS: begin
                  if (v32[31] || v32 > 32'(cfg_i.max_docs)) begin
                    d.tag = smp_pkg::TagError; d.err = smp_pkg::ErrDocCount;
                    halted_d = 1'b1;
                  end else begin
                    d.tag = smp_pkg::TagDocs; d.value = 64'(v32);
                    phase_d = PH_DELGEN;
                  end
                end
                PH_DELGEN: begin
                  d.tag = smp_pkg::TagDelGen; d.value = acc_n;
                  phase_d = PH_OFFSET;
                end
                PH_OFFSET: begin
                  d.tag = smp_pkg::TagOffset; d.value = {{32{v32[31]}}, v32};
                  if (v32 == 32'hFFFF_FFFF) begin
                    phase_d = PH_NORM;
                  end else begin
                    phase_d = PH_STORE_LEN; vsh_d = '0; acc_d = '0;
                  end
                end
                default: begin
                  // norm generation word
                  if (v32 != cfg_i.no_norm_gen_value) begin
                    d.tag = smp_pkg::TagError; d.err = smp_pkg::ErrSentinel;
                    halted_d = 1'b1;
                  end else begin
                    d.has_main = 1'b0;
                    phase_d = PH_COMPOUND;
                  end
                end
              endcase
            end
          end
          PH_NAME_LEN, PH_STORE_LEN: begin
            if (vsh_q >= 6'd32) begin
              d.has_main = 1'b1; d.tag = smp_pkg::TagError; d.err = smp_pkg::ErrVint;
              halted_d = 1'b1;
            end else begin
              acc_d = 64'(acc_l);
              if (b[7]) begin
                vsh_d = vsh_q + 6'd7;
              end else begin
                vsh_d = '0;
                if (acc_l == 32'd0 || acc_l[31]) begin
                  d.has_main = 1'b1;
                  d.tag      = is_name ? smp_pkg::TagNameByte : smp_pkg::TagStoreByte;
                  d.str_end  = 1'b1;
                  d.empty    = 1'b1;
                  phase_d    = is_name ? PH_DOCS : PH_STORE_COMPOUND;
                end else begin
                  chars_d = acc_l[30:0];
                  cbl_d   = '0;
                  code_d  = '0;
                  phase_d = is_name ? PH_NAME_CHARS : PH_STORE_CHARS;
                end
              end
            end
          end
          PH_NAME_CHARS, PH_STORE_CHARS: begin
            if (cbl_c != 2'd0) begin
              code_d = code_c;
              cbl_d  = cbl_c;
            end else begin
              chars_d    = chars_dec;
              cbl_d      = '0;
              code_d     = '0;
              d.has_main = 1'b1;
              d.tag      = is_name ? smp_pkg::TagNameByte : smp_pkg::TagStoreByte;
              d.value    = 64'(code_c);
              d.str_end  = (chars_dec == 31'd0);
              if (code_c <= 25'h7F)        d.ulen = 3'd1;
              else if (code_c <= 25'h7FF)  d.ulen = 3'd2;
              else if (code_c <= 25'hFFFF) d.ulen = 3'd3;
              else                         d.ulen = 3'd4;
              if (chars_dec == 31'd0) begin
                phase_d = is_name ? PH_DOCS : PH_STORE_COMPOUND;
              end
            end
          end
          PH_STORE_COMPOUND: begin
            d.has_main = 1'b1; d.tag = smp_pkg::TagStoreCmpd;
            d.value = 64'(b != 8'd0);
            phase_d = PH_NORM;
          end
          PH_NORM: begin
            d.has_main = 1'b1; d.tag = smp_pkg::TagSingleNorm;
            d.value = 64'(b != 8'd0);
            phase_d = PH_NORMGEN;
          end
          PH_COMPOUND: begin
            d.has_main = 1'b1; d.tag = smp_pkg::TagCompound;
            d.value = {{56{b[7]}}, b};
            idx_d  = idx_q + COUNT_WIDTH'(1);
            segs_d = segs_dec;
            if (segs_dec == '0) begin
              d.add_done = 1'b1;
              halted_d   = 1'b1;
            end else begin
              phase_d = PH_NAME_LEN; vsh_d = '0; acc_d = '0;
            end
          end
          default: halted_d = 1'b1;
        endcase
        if (in_data_i.final_byte && !halted_d) d.add_trunc = 1'b1;
      end
      d.post_seg = 32'(idx_d);
      if (in_data_i.final_byte) begin
        // rearm for the next buffer
        phase_d  = PH_FORMAT;
        fbc_d    = '0;
        acc_d    = '0;
        vsh_d    = '0;
        chars_d  = '0;
        cbl_d    = '0;
        code_d   = '0;
        segs_d   = '0;
        idx_d    = '0;
        halted_d = 1'b0;
      end
    end
  end

  assign desc_o = d;
  assign push_o = accept_i && (d.has_main || d.add_done || d.add_trunc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_FORMAT;
      fbc_q    <= '0;
      acc_q    <= '0;
      vsh_q    <= '0;
      chars_q  <= '0;
      cbl_q    <= '0;
      code_q   <= '0;
      segs_q   <= '0;
      idx_q    <= '0;
      halted_q <= 1'b0;
    end else begin
      phase_q  <= phase_d;
      fbc_q    <= fbc_d;
      acc_q    <= acc_d;
      vsh_q    <= vsh_d;
      chars_q  <= chars_d;
      cbl_q    <= cbl_d;
      code_q   <= code_d;
      segs_q   <= segs_d;
      idx_q    <= idx_d;
      halted_q <= halted_d;
    end
  end

endmodule

// ===== src/smp_queue.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smp_queue
// Short descriptor queue between parser front and result back end.
// ---------------------------------------------------------------------------
`include "segment_manifest_parser_defines.svh"
module smp_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  smp_pkg::desc_t data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output smp_pkg::desc_t data_o
);

  localparam int unsigned Depth = smp_pkg::QueueDepth;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  smp_pkg::desc_t  mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= (wr_q == PtrW'(Depth - 1)) ? '0 : wr_q + PtrW'(1);
      if (pop_i)  rd_q <= (rd_q == PtrW'(Depth - 1)) ? '0 : rd_q + PtrW'(1);
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + CntW'(1);
        2'b01:   cnt_q <= cnt_q - CntW'(1);
        default: cnt_q <= cnt_q;
      endcase
    end
  end

  `SMP_ASSERT_NEVER(a_no_overflow, push_i && full_o)
  `SMP_ASSERT_NEVER(a_no_underflow, pop_i && !valid_o)
  `SMP_ASSERT(a_count_bound, cnt_q <= CntW'(Depth))

endmodule

// ===== src/smp_back.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// smp_back
// Expands run descriptors into result transfers through an output register.
// ---------------------------------------------------------------------------
module smp_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  smp_pkg::desc_t q_data_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output smp_pkg::out_t  out_data_o
);

  logic [2:0]    k_q, n_main, n_tot;
  logic          load, last, is_main;
  logic          ov_q;
  smp_pkg::out_t out_q, res;

  always_comb begin
    n_main  = q_data_i.has_main ? ((q_data_i.ulen == 3'd0) ? 3'd1 : q_data_i.ulen) : 3'd0;
    n_tot   = n_main + 3'(q_data_i.add_done | q_data_i.add_trunc);
    is_main = (k_q < n_main);
    last    = (k_q == n_tot - 3'd1);
    load    = q_valid_i && (!ov_q || !out_stall_i);

    res             = '0;
    res.last_of_run = last;
    if (is_main) begin
      res.field_tag      = q_data_i.tag;
      res.segment_number = q_data_i.seg[23:0];
      if (q_data_i.ulen != 3'd0) begin
        res.field_value = 64'(smp_pkg::utf8_byte(q_data_i.value[24:0], q_data_i.ulen, k_q));
        res.string_end  = q_data_i.str_end && (k_q == q_data_i.ulen - 3'd1);
      end else begin
        res.field_value  = q_data_i.value;
        res.string_end   = q_data_i.str_end;
        res.empty_string = q_data_i.empty;
        res.error_code   = q_data_i.err;
      end
    end else if (q_data_i.add_done) begin
      res.field_tag      = smp_pkg::TagDone;
      res.field_value    = 64'(q_data_i.post_seg);
      res.segment_number = q_data_i.post_seg[23:0];
      res.manifest_done  = 1'b1;
    end else begin
      res.field_tag      = smp_pkg::TagError;
      res.error_code     = smp_pkg::ErrTruncated;
      res.segment_number = q_data_i.post_seg[23:0];
    end
  end

  assign pop_o       = load && last;
  assign out_valid_o = ov_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i) begin
    if (load) out_q <= res;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
      k_q  <= '0;
    end else begin
      if (load)              ov_q <= 1'b1;
      else if (!out_stall_i) ov_q <= 1'b0;
      if (load) k_q <= last ? 3'd0 : k_q + 3'd1;
    end
  end

endmodule

// ===== src/segment_manifest_parser.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// segment_manifest_parser
// Streaming segment manifest parser with tagged field results.
// ---------------------------------------------------------------------------
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+-------------------------------
//  in       | input     | in_valid / stall  | smp_pkg::in_t  (one byte)
//  out      | output    | out_valid / stall | smp_pkg::out_t (one field)
//  apb      | input     | psel/penable      | 32-bit register access
//
//  The front parses one byte per cycle (its next state is combinational
//  logic), so input runs at one transfer per clock while the queue has
//  room. The back end sends one result per clock from its output
//  register while the output is not stalled; a byte can cause up to five
//  results (a four-byte character plus truncation error).
//  Reset clears all parse state and loads the register defaults.
//  in_stall_o rises only when the two-entry descriptor queue is full.
// ---------------------------------------------------------------------------
module segment_manifest_parser #(
  parameter int unsigned COUNT_WIDTH = smp_pkg::CountWidthDefault
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  smp_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output smp_pkg::out_t out_data_o,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [3:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  smp_pkg::cfg_t  cfg_q;
  smp_pkg::desc_t f_desc, q_desc;
  logic           accept, push, pop, q_full, q_valid, wr_en;
  logic [1:0]     reg_idx;

  // ---- configuration registers ----
  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_comb begin
    case (reg_idx)
      smp_pkg::RegExpFormat: prdata = cfg_q.expected_format;
      smp_pkg::RegNoNormGen: prdata = cfg_q.no_norm_gen_value;
      smp_pkg::RegMaxDocs:   prdata = 32'(cfg_q.max_docs);
      smp_pkg::RegBufBytes:  prdata = 32'(cfg_q.buffer_bytes);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.expected_format   <= smp_pkg::ExpFormatReset;
      cfg_q.no_norm_gen_value <= smp_pkg::NoNormGenReset;
      cfg_q.max_docs          <= smp_pkg::MaxDocsReset;
      cfg_q.buffer_bytes      <= smp_pkg::BufBytesReset;
    end else if (wr_en) begin
      case (reg_idx)
        smp_pkg::RegExpFormat: cfg_q.expected_format   <= pwdata;
        smp_pkg::RegNoNormGen: cfg_q.no_norm_gen_value <= pwdata;
        smp_pkg::RegMaxDocs:   cfg_q.max_docs          <= pwdata[30:0];
        smp_pkg::RegBufBytes:  cfg_q.buffer_bytes      <= pwdata[23:0];
        default:               cfg_q                   <= cfg_q;
      endcase
    end
  end

  // ---- byte transfer into the front ----
  assign in_stall_o = q_full;
  assign accept     = in_valid_i && !q_full;

  smp_front #(
    .COUNT_WIDTH(COUNT_WIDTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .cfg_i     (cfg_q),
    .push_o    (push),
    .desc_o    (f_desc)
  );

  // decouples the parser from output stalls
  smp_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (f_desc),
    .pop_i   (pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .data_o  (q_desc)
  );

  smp_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_data_i    (q_desc),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: segment manifest parser
// Sends manifests one byte per transfer: well-formed ones with random content,
// broken and truncated ones, and noise. Several register settings and idle
// patterns are used. A software copy of the parser predicts every tagged
// result, and each result is checked field by field.
// ----------------------------------------------------------------------------
module tb;

  localparam int CycleLimit = 400000;
  localparam int HoldCycles = 300;

  typedef enum int {
    PhFormat, PhVersion, PhCounter, PhSegCount, PhNameLen, PhNameChars,
    PhDocs, PhDelGen, PhOffset, PhStoreLen, PhStoreChars, PhStoreCmpd,
    PhNorm, PhNormGen, PhCompound
  } parse_e;

  // kinds of generated manifest
  typedef enum int {
    MfGood, MfBadFormat, MfBadSegs, MfBadDocs, MfBadSentinel,
    MfLongVint, MfNegLen, MfTrunc, MfCorrupt, MfNoise
  } mf_e;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  smp_pkg::in_t in_data = '0;
  logic out_stall = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic in_stall, out_valid, pready;
  smp_pkg::out_t out_data;
  logic [31:0] prdata;

  segment_manifest_parser u_dut (
    .clk_i(clk), .rst_ni(rst_n),
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial forever #4 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Parser shadow: register copies and parse state
  // ---------------------------------------------------------------------------
  logic [31:0] cfg_format = smp_pkg::ExpFormatReset;
  logic [31:0] cfg_norm_gen = smp_pkg::NoNormGenReset;
  logic [30:0] cfg_max_docs = smp_pkg::MaxDocsReset;
  logic [23:0] cfg_buf_bytes = smp_pkg::BufBytesReset;

  parse_e      phase;
  int unsigned byte_cnt;
  logic [63:0] acc;
  int unsigned vshift;
  logic [31:0] chars_left;
  int unsigned cont_left;
  logic [24:0] code_acc;
  logic [23:0] segs_left;
  logic [23:0] seg_idx;
  logic        halted;

  smp_pkg::out_t field_q[$];     // results of the byte being parsed
  smp_pkg::out_t expect_q[$];    // results still owed by the block
  smp_pkg::in_t  byte_q[$];      // bytes waiting for the driver
  smp_pkg::in_t  build_q[$];     // manifest under construction

  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;
  bit in_taken = 1'b0;

  function void rearm();
    phase = PhFormat;
    byte_cnt = 0;
    acc = '0;
    vshift = 0;
    chars_left = '0;
    cont_left = 0;
    code_acc = '0;
    segs_left = '0;
    seg_idx = '0;
    halted = 1'b0;
  endfunction

  function void emit(logic [3:0] tag, logic [63:0] val, logic send, logic empty,
                     logic [2:0] err, logic done);
    smp_pkg::out_t r;
    if (field_q.size() >= 5) return;
    r.field_tag = tag;
    r.field_value = val;
    r.segment_number = seg_idx;
    r.string_end = send;
    r.empty_string = empty;
    r.error_code = err;
    r.manifest_done = done;
    r.last_of_run = 1'b0;
    field_q.insert(field_q.size(), r);
  endfunction

  function void fail(logic [2:0] err);
    emit(smp_pkg::TagError, '0, 1'b0, 1'b0, err, 1'b0);
    halted = 1'b1;
  endfunction

  function logic [63:0] sext32(logic [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

  // big-endian integer field; true once n bytes are in
  function bit take_int(logic [7:0] b, int unsigned n);
    acc = (acc << 8) | 64'(b);
    if (byte_cnt + 1 >= n) begin
      byte_cnt = 0;
      return 1'b1;
    end
    byte_cnt++;
    return 1'b0;
  endfunction

  function void start_len(parse_e ph);
    phase = ph;
    vshift = 0;
    acc = '0;
  endfunction

  function void emit_code(logic [3:0] tag, logic [24:0] c, logic last);
    if (c <= 25'h7F) begin
      emit(tag, 64'(c), last, 1'b0, smp_pkg::ErrNone, 1'b0);
    end else if (c <= 25'h7FF) begin
      emit(tag, 64'(8'hC0 | 8'(c >> 6)), 1'b0, 1'b0, smp_pkg::ErrNone, 1'b0);
      emit(tag, 64'(8'h80 | c[5:0]), last, 1'b0, smp_pkg::ErrNone, 1'b0);
    end else if (c <= 25'hFFFF) begin
      emit(tag, 64'(8'hE0 | 8'(c >> 12)), 1'b0, 1'b0, smp_pkg::ErrNone, 1'b0);
      emit(tag, 64'(8'h80 | c[11:6]), 1'b0, 1'b0, smp_pkg::ErrNone, 1'b0);
      emit(tag, 64'(8'h80 | c[5:0]), last, 1'b0, smp_pkg::ErrNone, 1'b0);
    end else begin
      // oversized leads are cut to one byte
      emit(tag, 64'(8'(8'hF0 | (c >> 18))), 1'b0, 1'b0, smp_pkg::ErrNone, 1'b0);
      emit(tag, 64'(8'h80 | c[17:12]), 1'b0, 1'b0, smp_pkg::ErrNone, 1'b0);
      emit(tag, 64'(8'h80 | c[11:6]), 1'b0, 1'b0, smp_pkg::ErrNone, 1'b0);
      emit(tag, 64'(8'h80 | c[5:0]), last, 1'b0, smp_pkg::ErrNone, 1'b0);
    end
  endfunction

  // VInt character count of a string field
  function void len_byte(logic [7:0] b, logic [3:0] tag, parse_e chars_ph,
                         parse_e after_ph);
    logic [31:0] w;
    if (vshift >= 32) begin
      fail(smp_pkg::ErrVint);
      return;
    end
    acc = (acc | (64'(b[6:0]) << vshift)) & 64'hFFFF_FFFF;
    if (b[7]) begin
      vshift += 7;
      return;
    end
    w = acc[31:0];
    vshift = 0;
    if (w == 0 || w[31]) begin
      emit(tag, '0, 1'b1, 1'b1, smp_pkg::ErrNone, 1'b0);
      phase = after_ph;
    end else begin
      chars_left = w;
      cont_left = 0;
      code_acc = '0;
      phase = chars_ph;
    end
  endfunction

  function void char_byte(logic [7:0] b, logic [3:0] tag, parse_e after_ph);
    if (cont_left == 0) begin
      if (!b[7]) begin
        code_acc = 25'(b);
      end else if (b[7:5] == 3'b110) begin
        code_acc = 25'(b[4:0]);
        cont_left = 1;
      end else if (b[7:4] == 4'b1110) begin
        code_acc = 25'(b[3:0]);
        cont_left = 2;
      end else begin
        code_acc = 25'(b[6:0]);
        cont_left = 3;
      end
    end else begin
      code_acc = (code_acc << 6) | 25'(b[5:0]);
      cont_left--;
    end
    if (cont_left != 0) return;
    chars_left--;
    emit_code(tag, code_acc, chars_left == 0);
    code_acc = '0;
    if (chars_left == 0) phase = after_ph;
  endfunction

  function void next_segment();
    if (segs_left == 0) begin
      emit(smp_pkg::TagDone, 64'(seg_idx), 1'b0, 1'b0, smp_pkg::ErrNone, 1'b1);
      halted = 1'b1;
    end else begin
      start_len(PhNameLen);
    end
  endfunction

  function void parse_byte(logic [7:0] b);
    logic [31:0] v;
    case (phase)
      PhFormat: if (take_int(b, 4)) begin
        if (acc[31:0] != cfg_format) fail(smp_pkg::ErrFormat);
        else phase = PhVersion;
      end
      PhVersion: if (take_int(b, 8)) begin
        emit(smp_pkg::TagVersion, acc, 1'b0, 1'b0, smp_pkg::ErrNone, 1'b0);
        phase = PhCounter;
      end
      PhCounter: if (take_int(b, 4)) begin
        emit(smp_pkg::TagCounter, sext32(acc[31:0]), 1'b0, 1'b0, smp_pkg::ErrNone, 1'b0);
        phase = PhSegCount;
      end
      PhSegCount: if (take_int(b, 4)) begin
        v = acc[31:0];
        if (v[31] || v > 32'(cfg_buf_bytes) || v > 32'hFF_FFFF) begin
          fail(smp_pkg::ErrSegCount);
        end else begin
          emit(smp_pkg::TagSegCount, 64'(v), 1'b0, 1'b0, smp_pkg::ErrNone, 1'b0);
          segs_left = v[23:0];
          seg_idx = '0;
          next_segment();
        end
      end
      PhNameLen:   len_byte(b, smp_pkg::TagNameByte, PhNameChars, PhDocs);
      PhNameChars: char_byte(b, smp_pkg::TagNameByte, PhDocs);
      PhDocs: if (take_int(b, 4)) begin
        v = acc[31:0];
        if (v[31] || v > 32'(cfg_max_docs)) begin
          fail(smp_pkg::ErrDocCount);
        end else begin
          emit(smp_pkg::TagDocs, 64'(v), 1'b0, 1'b0, smp_pkg::ErrNone, 1'b0);
          phase = PhDelGen;
        end
      end
      PhDelGen: if (take_int(b, 8)) begin
        emit(smp_pkg::TagDelGen, acc, 1'b0, 1'b0, smp_pkg::ErrNone, 1'b0);
        phase = PhOffset;
      end
      PhOffset: if (take_int(b, 4)) begin
        v = acc[31:0];
        emit(smp_pkg::TagOffset, sext32(v), 1'b0, 1'b0, smp_pkg::ErrNone, 1'b0);
        if (v == 32'hFFFF_FFFF) phase = PhNorm;
        else start_len(PhStoreLen);
      end
      PhStoreLen:   len_byte(b, smp_pkg::TagStoreByte, PhStoreChars, PhStoreCmpd);
      PhStoreChars: char_byte(b, smp_pkg::TagStoreByte, PhStoreCmpd);
      PhStoreCmpd: begin
        emit(smp_pkg::TagStoreCmpd, 64'(b != 0), 1'b0, 1'b0, smp_pkg::ErrNone, 1'b0);
        phase = PhNorm;
      end
      PhNorm: begin
        emit(smp_pkg::TagSingleNorm, 64'(b != 0), 1'b0, 1'b0, smp_pkg::ErrNone, 1'b0);
        phase = PhNormGen;
      end
      PhNormGen: if (take_int(b, 4)) begin
        if (acc[31:0] != cfg_norm_gen) fail(smp_pkg::ErrSentinel);
        else phase = PhCompound;
      end
      PhCompound: begin
        emit(smp_pkg::TagCompound, {{56{b[7]}}, b}, 1'b0, 1'b0, smp_pkg::ErrNone, 1'b0);
        seg_idx = seg_idx + 1'b1;
        segs_left = segs_left - 1'b1;
        next_segment();
      end
      default: halted = 1'b1;
    endcase
  endfunction

  // one accepted byte: append its results to the expectations
  function void predict_byte(smp_pkg::in_t it);
    field_q.delete();
    if (!halted) begin
      parse_byte(it.data_byte);
      if (it.final_byte && !halted) fail(smp_pkg::ErrTruncated);
    end
    if (it.final_byte) rearm();
    if (field_q.size() > 0) field_q[field_q.size() - 1].last_of_run = 1'b1;
    foreach (field_q[i]) expect_q.insert(expect_q.size(), field_q[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Manifest builder
  // ---------------------------------------------------------------------------
  function void put(logic [7:0] b);
    smp_pkg::in_t it;
    it.data_byte = b;
    it.final_byte = 1'b0;
    build_q.insert(build_q.size(), it);
  endfunction

  function void put_int(logic [63:0] v, int n);
    for (int i = n - 1; i >= 0; i--) put(v[8*i +: 8]);
  endfunction

  function void put_vint(logic [31:0] v);
    while (v >= 32'h80) begin
      put({1'b1, v[6:0]});
      v = v >> 7;
    end
    // sometimes a redundant zero group
    if ($urandom_range(3) == 0 && v < 32'h10) begin
      put({1'b1, v[6:0]});
      put(8'h00);
    end else begin
      put(v[7:0]);
    end
  endfunction

  function void put_string(bit neg_len);
    int n;
    int kind;
    if (neg_len) begin
      put_vint(32'h8000_0000 | $urandom);
      return;
    end
    n = $urandom_range(4);
    put_vint(32'(n));
    repeat (n) begin
      kind = $urandom_range(3);
      case (kind)
        0: put(8'($urandom_range(8'h7F)));
        1: begin
          put(8'($urandom_range(8'hDF, 8'hC0)));
          put(8'($urandom));
        end
        2: begin
          put(8'($urandom_range(8'hEF, 8'hE0)));
          repeat (2) put(8'($urandom));
        end
        default: begin
          // any other lead byte opens a four-byte form
          if ($urandom_range(1)) put(8'($urandom_range(8'hBF, 8'h80)));
          else put(8'($urandom_range(8'hFF, 8'hF0)));
          repeat (3) put(8'($urandom));
        end
      endcase
    end
  endfunction

  function void build_manifest(mf_e kind);
    logic [31:0] segs, docs, v;
    int lim, cut, bad_seg;
    build_q.delete();
    if (kind == MfNoise) begin
      repeat ($urandom_range(30, 8)) put(8'($urandom));
      foreach (build_q[i]) build_q[i].final_byte = ($urandom_range(15) == 0);
    end else begin
      v = cfg_format;
      if (kind == MfBadFormat) v[$urandom_range(31)] ^= 1'b1;
      put_int(64'(v), 4);
      put_int({$urandom, $urandom}, 8);
      put_int(64'($urandom), 4);
      lim = (cfg_buf_bytes < 2) ? int'(cfg_buf_bytes) : 2;
      segs = 32'($urandom_range(lim));
      if (kind inside {MfBadDocs, MfBadSentinel, MfLongVint, MfNegLen} && lim > 0 &&
          segs == 0) segs = 1;
      if (kind == MfBadSegs) begin
        if (cfg_buf_bytes == 24'hFF_FFFF || $urandom_range(1)) segs = 32'h8000_0000 | $urandom;
        else segs = 32'(cfg_buf_bytes) + 1 + $urandom_range(3);
      end
      put_int(64'(segs), 4);
      bad_seg = (segs > 0 && segs < 4) ? $urandom_range(segs - 1) : 0;
      // a rejected count ends the parse, so no records follow it
      for (int s = 0; kind != MfBadSegs && s < segs && s < 4; s++) begin
        if (kind == MfLongVint && s == bad_seg) begin
          repeat (5) put(8'h80 | 8'($urandom));
          put(8'($urandom));
        end else begin
          put_string(kind == MfNegLen && s == bad_seg);
        end
        docs = 32'($urandom_range(cfg_max_docs));
        if (kind == MfBadDocs && s == bad_seg) begin
          if (cfg_max_docs == 31'h7FFF_FFFF || $urandom_range(1)) docs = 32'h8000_0000 | $urandom;
          else docs = 32'(cfg_max_docs) + 1;
        end
        put_int(64'(docs), 4);
        put_int({$urandom, $urandom}, 8);
        if ($urandom_range(1)) begin
          put_int(64'hFFFF_FFFF, 4);
        end else begin
          put_int(64'($urandom), 4);
          // a random word can still be -1; the parser then skips the store name
          if (build_q[build_q.size() - 1].data_byte != 8'hFF ||
              build_q[build_q.size() - 2].data_byte != 8'hFF) begin
            put_string(1'b0);
            put(($urandom_range(1)) ? 8'($urandom) : 8'h00);
          end
        end
        put(($urandom_range(1)) ? 8'($urandom) : 8'h00);
        v = cfg_norm_gen;
        if (kind == MfBadSentinel && s == bad_seg) v = v + 1 + $urandom_range(7);
        put_int(64'(v), 4);
        put(8'($urandom));
      end
      // bytes after the end are ignored
      if ($urandom_range(3) == 0) repeat ($urandom_range(3, 1)) put(8'($urandom));
      if (kind == MfCorrupt) build_q[$urandom_range(build_q.size() - 1)].data_byte ^=
          8'(1 << $urandom_range(7));
      if (kind == MfTrunc) begin
        cut = $urandom_range(build_q.size() - 1, 1);
        while (build_q.size() > cut) void'(build_q.pop_back());
      end
      build_q[build_q.size() - 1].final_byte = 1'b1;
    end
    foreach (build_q[i]) byte_q.insert(byte_q.size(), build_q[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Input driver: new transfer offered at the falling edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) begin
      predict_byte(in_data);
      in_taken = 1'b1;
    end
  end

  always @(negedge clk) begin
    if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (rst_n && byte_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        in_data <= byte_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Output side: stall pattern, long hold-off and result checker
  // ---------------------------------------------------------------------------
  int hold_left = 0;
  int hold_seen = 0;
  always @(posedge clk) begin
    if (hold_req != hold_seen) begin
      hold_seen <= hold_req;
      hold_left <= HoldCycles;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
  end

  always @(negedge clk) out_stall <= (hold_left > 0) || ($urandom_range(99) < recv_stall_pct);

  always @(posedge clk) begin
    smp_pkg::out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expect_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("tb: unexpected result %p", out_data);
      end else begin
        want = expect_q.pop_front();
        if (out_data.field_tag !== want.field_tag ||
            out_data.field_value !== want.field_value ||
            out_data.segment_number !== want.segment_number ||
            out_data.string_end !== want.string_end ||
            out_data.empty_string !== want.empty_string ||
            out_data.error_code !== want.error_code ||
            out_data.manifest_done !== want.manifest_done ||
            out_data.last_of_run !== want.last_of_run) begin
          errors++;
          if (errors <= 10) $display("tb: mismatch\n  exp %p\n  got %p", want, out_data);
        end
      end
    end
  end

  // watchdog
  int cycles = 0;
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Register access and sequencing
  // ---------------------------------------------------------------------------
  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      smp_pkg::RegExpFormat: cfg_format = val;
      smp_pkg::RegNoNormGen: cfg_norm_gen = val;
      smp_pkg::RegMaxDocs:   cfg_max_docs = val[30:0];
      default:               cfg_buf_bytes = val[23:0];
    endcase
  endtask

  task automatic set_regs(logic [31:0] fmt, logic [31:0] nng, logic [31:0] mdocs,
                          logic [31:0] bufb);
    write_reg(smp_pkg::RegExpFormat, fmt);
    write_reg(smp_pkg::RegNoNormGen, nng);
    write_reg(smp_pkg::RegMaxDocs, mdocs);
    write_reg(smp_pkg::RegBufBytes, bufb);
  endtask

  // wait until every byte is taken and every result has come back
  task automatic drain();
    while (byte_q.size() > 0 || in_valid || expect_q.size() > 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic random_phase(int nbytes);
    int start_size;
    int r;
    mf_e kind;
    start_size = 0;
    while (start_size < nbytes) begin
      r = $urandom_range(99);
      if (r < 65) kind = MfGood;
      else if (r < 75) kind = MfNoise;
      else kind = mf_e'($urandom_range(int'(MfCorrupt), int'(MfBadFormat)));
      build_manifest(kind);
      start_size += build_q.size();
      while (byte_q.size() > 64) @(posedge clk);
    end
    drain();
  endtask

  initial begin
    rearm();
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n = 1'b1;

    // directed: reset registers, so only an empty manifest can succeed
    build_manifest(MfGood);
    build_manifest(MfBadFormat);
    build_manifest(MfBadSegs);
    build_manifest(MfTrunc);
    drain();

    // directed: register extremes, vint, length, doc count, sentinel and segment count cases
    set_regs(32'h8000_0000, 32'h0000_0000, 32'h7FFF_FFFF, 32'h00FF_FFFF);
    build_manifest(MfLongVint);
    build_manifest(MfNegLen);
    build_manifest(MfBadDocs);
    build_manifest(MfBadSentinel);
    build_manifest(MfBadSegs);
    drain();

    // no idling, with a long output hold-off so the input backs up
    set_regs(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h1);
    hold_req++;
    random_phase(25);

    set_regs($urandom, $urandom, $urandom, 32'($urandom_range(3)));
    send_idle_pct = 78;
    random_phase(25);

    set_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h1000_0000, 32'h2);
    send_idle_pct = 0;
    recv_stall_pct = 78;
    random_phase(25);

    set_regs($urandom, $urandom, 32'($urandom_range(1000)), 32'h3);
    send_idle_pct = 15;
    recv_stall_pct = 15;
    random_phase(25);

    if (errors == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
